>>> rtl/core/mafs_pkg.sv
// Shared types, constants and lookup tables of the MPEG audio frame sync scanner.
`timescale 1ns / 1ps
`default_nettype none

package mafs_pkg;

  // Result status codes.
  localparam logic [1:0] STAT_FOUND  = 2'd0;
  localparam logic [1:0] STAT_UNSUP  = 2'd1;
  localparam logic [1:0] STAT_NONE   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MATCH_MASK = 1'b0;
  localparam logic CFG_START_SIG  = 1'b1;

  // Header field codes.
  localparam logic [7:0] SYNC1_CODE    = 8'hFF;
  localparam logic [2:0] SYNC2_CODE    = 3'h7;
  localparam logic [1:0] VER_RESERVED  = 2'b01;
  localparam logic [1:0] VER_MPEG1     = 2'b11;
  localparam logic [1:0] LAYER_NONE    = 2'b00;
  localparam logic [1:0] LAYER_III     = 2'b01;
  localparam logic [3:0] BRI_BAD       = 4'hF;
  localparam logic [1:0] SRI_BAD       = 2'b11;
  localparam logic [1:0] EMPH_BAD      = 2'b10;

  localparam logic [31:0] MASK_RESET   = 32'hFFFE0CC3;

  // Divider geometry: a 26-bit numerator over a 16-bit rate with an 11-bit quotient.
  localparam int NUM_W    = 26;
  localparam int DEN_W    = 16;
  localparam int QUO_W    = 11;
  localparam int DIV_CNT_W = 4;

  localparam int KBPS_W   = 9;
  localparam int LEN_W    = 11;
  localparam int DUR_W    = 8;
  localparam int SKIPPED_W = 16;

  // Frame coefficient times 1000, and samples per frame times 1000.
  localparam int COEF_V1_K = 144000;
  localparam int COEF_V2_K = 72000;
  localparam logic [NUM_W-1:0] DUR_NUM_V1 = NUM_W'(1152000);
  localparam logic [NUM_W-1:0] DUR_NUM_V2 = NUM_W'(576000);

  typedef struct packed {
    logic              hit;
    logic              supported;
    logic              pad;
    logic [KBPS_W-1:0] kbps;
    logic [DEN_W-1:0]  rate;
    logic [NUM_W-1:0]  len_numer;
    logic [NUM_W-1:0]  dur_numer;
    logic [31:0]       word;
    logic [31:0]       signature;
  } hdr_info_t;

  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic v1, input logic [3:0] bri);
    logic [KBPS_W-1:0] k;
    k = '0;
    if (v1) begin
      unique case (bri)
        4'd1: k = 9'd32;   4'd2: k = 9'd40;   4'd3: k = 9'd48;   4'd4: k = 9'd56;
        4'd5: k = 9'd64;   4'd6: k = 9'd80;   4'd7: k = 9'd96;   4'd8: k = 9'd112;
        4'd9: k = 9'd128;  4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
        4'd13: k = 9'd256; 4'd14: k = 9'd320;
        default: k = '0;
      endcase
    end else begin
      unique case (bri)
        4'd1: k = 9'd8;    4'd2: k = 9'd16;   4'd3: k = 9'd24;   4'd4: k = 9'd32;
        4'd5: k = 9'd40;   4'd6: k = 9'd48;   4'd7: k = 9'd56;   4'd8: k = 9'd64;
        4'd9: k = 9'd80;   4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
        4'd13: k = 9'd144; 4'd14: k = 9'd160;
        default: k = '0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [DEN_W-1:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
    logic [DEN_W-1:0] r;
    r = '0;
    unique case ({ver, sri})
      4'b0000: r = 16'd11025;
      4'b0001: r = 16'd12000;
      4'b0010: r = 16'd8000;
      4'b1000: r = 16'd22050;
      4'b1001: r = 16'd24000;
      4'b1010: r = 16'd16000;
      4'b1100: r = 16'd44100;
      4'b1101: r = 16'd48000;
      4'b1110: r = 16'd32000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Length numerator is a constant per table entry, so this folds into a table.
  function automatic logic [NUM_W-1:0] len_numer_lookup(input logic v1, input logic [3:0] bri);
    int prod;
    prod = int'(kbps_lookup(v1, bri)) * (v1 ? COEF_V1_K : COEF_V2_K);
    return NUM_W'(prod);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mpeg_audio_frame_sync_scanner.sv
// Top level of the MPEG audio frame sync scanner: byte hunt, frame skip and result register.
//
//   Channel  Ports                                  Carries
//   in       in_tvalid/in_tready/in_tdata/in_tlast  one stream byte, buffer end mark
//   out      out_tvalid/out_tready/out_tdata/tuser  header report or buffer-end status
//   cfg      cfg_we/cfg_index/cfg_wdata             match mask, start signature
//
// A byte that does not complete a supported Layer III header leaves the block idle.
// A supported header is sized in two passes of the shared 11-step divider (frame
// length, then frame duration) before the block returns to idle.
// Reset is synchronous and active low; it clears the hunt state and loads the
// reset mask and a zero signature.
// The input is held off while a division runs and while an unread result blocks the
// output register; a result taken in the same cycle frees the register for the next byte.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_frame_sync_scanner
  import mafs_pkg::*;
#(
  parameter int SKIP_COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_in_buffer
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] header_word, [40:32] bit_rate_kbps, [56:41] sample_rate_hz,
  // [67:57] frame_length, [75:68] frame_duration_ms, [91:76] bytes_skipped, [95:92] zero
  output logic [95:0]      out_tdata,
  output logic [1:0]       out_tuser,  // [1:0] status
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LEN  = 3'b010,
    S_DUR  = 3'b100
  } state_t;

  localparam int CNT_EXT_W = 32;

  state_t                      state_r, state_nxt;
  logic [23:0]                 window_r, window_nxt;
  logic [1:0]                  fill_r, fill_nxt;
  logic                        skip_mode_r, skip_mode_nxt;
  logic [LEN_W-1:0]            skip_rem_r, skip_rem_nxt;
  logic [31:0]                 locked_r, locked_nxt;
  logic [31:0]                 mask_r, mask_nxt;
  logic [SKIP_COUNT_WIDTH-1:0] skip_cnt_r, skip_cnt_nxt;

  // Header held while the divider works on it.
  logic [31:0]                 hw_r, hw_nxt;
  logic [KBPS_W-1:0]           kbps_r, kbps_nxt;
  logic [DEN_W-1:0]            rate_r, rate_nxt;
  logic [NUM_W-1:0]            dur_num_r, dur_num_nxt;
  logic                        pad_r, pad_nxt;
  logic                        last_r, last_nxt;
  logic [SKIPPED_W-1:0]        skipped_r, skipped_nxt;
  logic [LEN_W-1:0]            len_r, len_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  o_status_r, o_status_nxt;
  logic [31:0]                 o_hw_r, o_hw_nxt;
  logic [KBPS_W-1:0]           o_kbps_r, o_kbps_nxt;
  logic [DEN_W-1:0]            o_rate_r, o_rate_nxt;
  logic [LEN_W-1:0]            o_len_r, o_len_nxt;
  logic [DUR_W-1:0]            o_dur_r, o_dur_nxt;
  logic [SKIPPED_W-1:0]        o_skipped_r, o_skipped_nxt;

  hdr_info_t                   info;
  logic                        in_acc;
  logic                        div_start;
  logic [NUM_W-1:0]            div_numer;
  logic [DEN_W-1:0]            div_denom;
  logic                        div_done;
  logic [QUO_W-1:0]            div_quot;
  logic [LEN_W-1:0]            len_calc;
  logic [CNT_EXT_W-1:0]        cnt_ext;
  logic [SKIPPED_W-1:0]        cnt_sat;
  logic                        load_out;
  logic                        produced;

  mafs_hdr_dec u_dec (
    .window     (window_r),
    .data_byte  (in_tdata),
    .match_mask (mask_r),
    .locked_sig (locked_r),
    .info       (info)
  );

  mafs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cnt_ext  = CNT_EXT_W'(skip_cnt_r);
    cnt_sat  = (cnt_ext > CNT_EXT_W'(16'hFFFF)) ? 16'hFFFF : cnt_ext[SKIPPED_W-1:0];
    len_calc = div_quot + LEN_W'(pad_r);
  end

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    skip_mode_nxt = skip_mode_r;
    skip_rem_nxt  = skip_rem_r;
    locked_nxt    = locked_r;
    mask_nxt      = mask_r;
    skip_cnt_nxt  = skip_cnt_r;
    hw_nxt        = hw_r;
    kbps_nxt      = kbps_r;
    rate_nxt      = rate_r;
    dur_num_nxt   = dur_num_r;
    pad_nxt       = pad_r;
    last_nxt      = last_r;
    skipped_nxt   = skipped_r;
    len_nxt       = len_r;
    o_status_nxt  = o_status_r;
    o_hw_nxt      = o_hw_r;
    o_kbps_nxt    = o_kbps_r;
    o_rate_nxt    = o_rate_r;
    o_len_nxt     = o_len_r;
    o_dur_nxt     = o_dur_r;
    o_skipped_nxt = o_skipped_r;
    div_start     = 1'b0;
    div_numer     = info.len_numer;
    div_denom     = info.rate;
    load_out      = 1'b0;
    produced      = 1'b0;

    // Configuration should be written only while idle; the block itself does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATCH_MASK: mask_nxt = cfg_wdata;
        CFG_START_SIG:  locked_nxt = cfg_wdata;
        default:        mask_nxt = mask_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (skip_mode_r) begin
            // Dropping the body of the frame just reported.
            if (skip_rem_r == LEN_W'(1) || skip_rem_r == '0) begin
              skip_rem_nxt  = '0;
              skip_mode_nxt = 1'b0;
              window_nxt    = '0;
              fill_nxt      = '0;
            end else begin
              skip_rem_nxt = skip_rem_r - 1'b1;
            end
          end else if (fill_r != 2'd3) begin
            window_nxt = {window_r[15:0], in_tdata};
            fill_nxt   = fill_r + 1'b1;
          end else if (info.hit) begin
            produced   = 1'b1;
            window_nxt = '0;
            fill_nxt   = '0;
            skip_cnt_nxt = '0;
            if (!info.supported) begin
              // Matching but not a Layer III frame we can size: report and keep hunting.
              load_out      = 1'b1;
              o_status_nxt  = STAT_UNSUP;
              o_hw_nxt      = info.word;
              o_kbps_nxt    = '0;
              o_rate_nxt    = '0;
              o_len_nxt     = '0;
              o_dur_nxt     = '0;
              o_skipped_nxt = '0;
            end else begin
              // Lock onto this header and size the frame on the shared divider.
              locked_nxt  = info.signature;
              hw_nxt      = info.word;
              kbps_nxt    = info.kbps;
              rate_nxt    = info.rate;
              dur_num_nxt = info.dur_numer;
              pad_nxt     = info.pad;
              last_nxt    = in_tlast;
              skipped_nxt = cnt_sat;
              div_start   = 1'b1;
              state_nxt   = S_LEN;
            end
          end else begin
            window_nxt = info.word[23:0];
            if (!(&skip_cnt_r)) begin
              skip_cnt_nxt = skip_cnt_r + 1'b1;
            end
          end

          if (in_tlast) begin
            if (!produced) begin
              load_out      = 1'b1;
              o_status_nxt  = STAT_NONE;
              o_hw_nxt      = '0;
              o_kbps_nxt    = '0;
              o_rate_nxt    = '0;
              o_len_nxt     = '0;
              o_dur_nxt     = '0;
              o_skipped_nxt = '0;
            end
            // A buffer end drops the window and any frame skip, but keeps the lock.
            window_nxt    = '0;
            fill_nxt      = '0;
            skip_mode_nxt = 1'b0;
            skip_rem_nxt  = '0;
            skip_cnt_nxt  = '0;
          end
        end
      end
      S_LEN: begin
        if (div_done) begin
          len_nxt = len_calc;
          if (!last_r && (len_calc > LEN_W'(4))) begin
            skip_mode_nxt = 1'b1;
            skip_rem_nxt  = len_calc - LEN_W'(4);
          end
          div_start = 1'b1;
          div_numer = dur_num_r;
          div_denom = rate_r;
          state_nxt = S_DUR;
        end
      end
      S_DUR: begin
        if (div_done) begin
          load_out      = 1'b1;
          o_status_nxt  = STAT_FOUND;
          o_hw_nxt      = hw_r;
          o_kbps_nxt    = kbps_r;
          o_rate_nxt    = rate_r;
          o_len_nxt     = len_r;
          o_dur_nxt     = div_quot[DUR_W-1:0];
          o_skipped_nxt = skipped_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= '0;
      fill_r      <= '0;
      skip_mode_r <= 1'b0;
      skip_rem_r  <= '0;
      locked_r    <= '0;
      mask_r      <= MASK_RESET;
      skip_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      fill_r      <= fill_nxt;
      skip_mode_r <= skip_mode_nxt;
      skip_rem_r  <= skip_rem_nxt;
      locked_r    <= locked_nxt;
      mask_r      <= mask_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hw_r        <= hw_nxt;
    kbps_r      <= kbps_nxt;
    rate_r      <= rate_nxt;
    dur_num_r   <= dur_num_nxt;
    pad_r       <= pad_nxt;
    last_r      <= last_nxt;
    skipped_r   <= skipped_nxt;
    len_r       <= len_nxt;
    o_status_r  <= o_status_nxt;
    o_hw_r      <= o_hw_nxt;
    o_kbps_r    <= o_kbps_nxt;
    o_rate_r    <= o_rate_nxt;
    o_len_r     <= o_len_nxt;
    o_dur_r     <= o_dur_nxt;
    o_skipped_r <= o_skipped_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {4'b0000, o_skipped_r, o_dur_r, o_len_r, o_rate_r, o_kbps_r, o_hw_r};

  // The output register is always free while a header is being sized.
  a_out_free_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result register occupied during frame sizing");

  // The divider reports completion only while the sequencer waits on it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_LEN || state_r == S_DUR))
    else $error("divider finished outside a sizing step");

  // Frame skip always has bytes left to drop.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    skip_mode_r |-> (skip_rem_r != '0))
    else $error("frame skip active with nothing left to skip");

  // A finished frame-length pass is followed by the duration pass.
  a_len_to_dur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEN && div_done) |=> (state_r == S_DUR))
    else $error("length pass did not hand over to duration pass");

endmodule

`default_nettype wire

>>> rtl/core/mafs_hdr_dec.sv
// Header candidate decoder: match test, validity checks and table lookups.
`timescale 1ns / 1ps
`default_nettype none

module mafs_hdr_dec
  import mafs_pkg::*;
(
  input  wire logic [23:0] window,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] match_mask,
  input  wire logic [31:0] locked_sig,
  output hdr_info_t        info
);

  logic [31:0] w;
  logic [1:0]  ver;
  logic [1:0]  lay;
  logic [3:0]  bri;
  logic [1:0]  sri;
  logic        valid;
  logic        v1;

  always_comb begin
    w   = {window, data_byte};
    ver = w[20:19];
    lay = w[18:17];
    bri = w[15:12];
    sri = w[11:10];
    v1  = (ver == VER_MPEG1);
    valid = (w[31:24] == SYNC1_CODE) && (w[23:21] == SYNC2_CODE) &&
            (ver != VER_RESERVED) && (lay != LAYER_NONE) && (bri != BRI_BAD) &&
            (sri != SRI_BAD) && (w[1:0] != EMPH_BAD);

    info.word      = w;
    info.signature = w & match_mask;
    info.hit       = (locked_sig != '0) ? (info.signature == locked_sig) : valid;
    info.kbps      = kbps_lookup(v1, bri);
    info.rate      = rate_lookup(ver, sri);
    info.pad       = w[9];
    info.len_numer = len_numer_lookup(v1, bri);
    info.dur_numer = v1 ? DUR_NUM_V1 : DUR_NUM_V2;
    info.supported = (lay == LAYER_III) && (ver != VER_RESERVED) &&
                     (info.rate != '0) && (info.kbps != '0);
  end

endmodule

`default_nettype wire

>>> rtl/core/mafs_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mafs_divider
  import mafs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DEN_W-1:0] denom,
  output logic                  done,
  output logic [QUO_W-1:0]      quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [QUO_W-1:0]     num_r, num_nxt;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  // The numerator is known to stay below denom * 2^QUO_W, so its upper part starts
  // out already smaller than the divisor.
  always_comb begin
    trial    = {rem_r, num_r[QUO_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = DEN_W'(numer[NUM_W-1:QUO_W]);
      den_nxt  = denom;
      num_nxt  = numer[QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt = {num_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the MPEG audio frame sync scanner.
`timescale 1ns / 1ps

module tb
  import mafs_pkg::*;
();

  localparam int LIMIT = 600_000;   // cycles before the run is declared hung
  localparam int DRAIN = 40;        // lets a header still being sized finish; leave some margin
  localparam logic [1:0] VER_MPEG2  = 2'b10;
  localparam logic [1:0] VER_MPEG25 = 2'b00;

  // One reported result, in the order the fields leave the block.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [10:0] len;
    logic [7:0]  ms;
    logic [15:0] skipped;
  } report_t;

  // One row of the directed stream. Status and word matter only on rows
  // whose result is typed in here; the other rows go through the predictor.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [1:0]  status;
    logic [31:0] word;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MATCH_MASK;
  logic [31:0] cfg_wdata = 32'h0;

  mpeg_audio_frame_sync_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Scanner state as the predictor sees it. Values match the block after reset.
  logic [31:0] cfg_mask   = MASK_RESET;
  logic [31:0] locked_sig = 32'h0;
  logic [23:0] hunt_window = 24'h0;
  int          hunt_fill = 0;
  logic        in_frame = 1'b0;
  logic [10:0] frame_left = 11'h0;
  logic [15:0] miss_count = 16'h0;

  report_t expected_reports [$];
  int      reports_due = 0;
  int      reports_seen = 0;
  int      items_sent = 0;
  int      failures = 0;
  int      cycle_count = 0;
  int      stall_left = 0;
  bit      stall_done = 1'b0;

  // Directed stream: buffer ends, unsupported layer, free format, a locked match
  // that is unsupported, a header after a skipped byte, and buffer ends that cut
  // a frame short or fall on the last header byte.
  step_t directed_steps [24] = '{
    {8'h00, 1'b1, 1'b1, STAT_NONE,  32'h0000_0000},
    {8'hFF, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hFD, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h90, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h00, 1'b0, 1'b1, STAT_UNSUP, 32'hFFFD_9000},
    {8'hFF, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hFB, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h00, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h00, 1'b0, 1'b1, STAT_UNSUP, 32'hFFFB_0000},
    {8'hAB, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hFF, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hF3, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h17, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hFF, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h5A, 1'b1, 1'b1, STAT_NONE,  32'h0000_0000},
    {8'hFF, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hF3, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hF7, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hFF, 1'b0, 1'b1, STAT_UNSUP, 32'hFFF3_F7FF},
    {8'h00, 1'b1, 1'b1, STAT_NONE,  32'h0000_0000},
    {8'hFF, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hF3, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'h17, 1'b0, 1'b0, STAT_FOUND, 32'h0000_0000},
    {8'hFF, 1'b1, 1'b0, STAT_FOUND, 32'h0000_0000}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  // Layer III bitrate in kbps; zero for free format and the forbidden index.
  function automatic int layer3_kbps(input bit mpeg1, input logic [3:0] idx);
    case (idx)
      4'd1:  return mpeg1 ? 32 : 8;
      4'd2:  return mpeg1 ? 40 : 16;
      4'd3:  return mpeg1 ? 48 : 24;
      4'd4:  return mpeg1 ? 56 : 32;
      4'd5:  return mpeg1 ? 64 : 40;
      4'd6:  return mpeg1 ? 80 : 48;
      4'd7:  return mpeg1 ? 96 : 56;
      4'd8:  return mpeg1 ? 112 : 64;
      4'd9:  return mpeg1 ? 128 : 80;
      4'd10: return mpeg1 ? 160 : 96;
      4'd11: return mpeg1 ? 192 : 112;
      4'd12: return mpeg1 ? 224 : 128;
      4'd13: return mpeg1 ? 256 : 144;
      4'd14: return mpeg1 ? 320 : 160;
      default: return 0;
    endcase
  endfunction

  // MPEG-2 halves and MPEG-2.5 quarters the MPEG-1 rates.
  function automatic int sample_hz(input logic [1:0] ver, input logic [1:0] idx);
    int full;
    case (idx)
      2'd0: full = 44100;
      2'd1: full = 48000;
      2'd2: full = 32000;
      default: full = 0;
    endcase
    case (ver)
      VER_MPEG1:  return full;
      VER_MPEG2:  return full / 2;
      VER_MPEG25: return full / 4;
      default:    return 0;
    endcase
  endfunction

  function automatic bit header_ok(input logic [31:0] w);
    return w[31:24] == SYNC1_CODE && w[23:21] == SYNC2_CODE &&
           w[20:19] != VER_RESERVED && w[18:17] != LAYER_NONE &&
           w[15:12] != BRI_BAD && w[11:10] != SRI_BAD && w[1:0] != EMPH_BAD;
  endfunction

  // Decodes a matched header into the report it produces, apart from the
  // skipped-byte count, which depends on the hunt history.
  function automatic report_t parse_header(input logic [31:0] w);
    report_t r;
    bit      mpeg1;
    int      kbps;
    int      hz;
    int      len;
    r = '0;
    r.word = w;
    mpeg1 = (w[20:19] == VER_MPEG1);
    kbps = layer3_kbps(mpeg1, w[15:12]);
    hz = sample_hz(w[20:19], w[11:10]);
    if (w[18:17] != LAYER_III || w[20:19] == VER_RESERVED || hz == 0 || kbps == 0) begin
      r.status = STAT_UNSUP;
    end else begin
      len = ((mpeg1 ? 144 : 72) * kbps * 1000) / hz + int'(w[9]);
      r.status = STAT_FOUND;
      r.kbps = 9'(kbps);
      r.hz = 16'(hz);
      r.len = 11'(len);
      r.ms = 8'(((mpeg1 ? 1152 : 576) * 1000) / hz);
    end
    return r;
  endfunction

  // Advances the scanner by one byte and returns the result it owes, if any.
  task automatic scan_byte(input logic [7:0] b, input logic last,
                           output bit got, output report_t r);
    logic [31:0] w;
    bit          hit;
    got = 1'b0;
    r = '0;
    if (in_frame) begin
      // Frame body: count down, then hunt afresh at the next byte.
      if (frame_left != 0) frame_left--;
      if (frame_left == 0) begin
        in_frame = 1'b0;
        hunt_window = '0;
        hunt_fill = 0;
      end
    end else if (hunt_fill < 3) begin
      hunt_window = {hunt_window[15:0], b};
      hunt_fill++;
    end else begin
      w = {hunt_window, b};
      hit = (locked_sig != 0) ? ((w & cfg_mask) == locked_sig) : header_ok(w);
      if (hit) begin
        r = parse_header(w);
        got = 1'b1;
        hunt_window = '0;
        hunt_fill = 0;
        if (r.status == STAT_FOUND) begin
          r.skipped = miss_count;
          locked_sig = w & cfg_mask;
          if (r.len > 4) begin
            in_frame = 1'b1;
            frame_left = r.len - 11'd4;
          end
        end
        miss_count = '0;
      end else begin
        hunt_window = w[23:0];
        if (miss_count != 16'hFFFF) miss_count++;
      end
    end
    if (last) begin
      if (!got) begin
        r.status = STAT_NONE;
        got = 1'b1;
      end
      hunt_window = '0;
      hunt_fill = 0;
      in_frame = 1'b0;
      frame_left = '0;
      miss_count = '0;
    end
  endtask

  // Both sides run without gaps for a stretch early in the random traffic.
  function automatic bit steady();
    return cycle_count >= 1500 && cycle_count < 2500;
  endfunction

  function automatic logic buffer_end();
    return $urandom_range(0, 149) == 0;
  endfunction

  // A valid header, mostly with low bitrates so that frames stay short.
  function automatic logic [31:0] random_header(input bit wide_rate);
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [1:0]  emph;
    logic [3:0]  bri;
    logic [31:0] bits;
    int          pick;
    pick = $urandom_range(0, 9);
    ver = (pick < 4) ? VER_MPEG25 : ((pick < 8) ? VER_MPEG2 : VER_MPEG1);
    lay = LAYER_III;
    if ($urandom_range(0, 19) == 0) lay = 2'($urandom_range(1, 3));
    bri = wide_rate ? 4'($urandom_range(1, 14)) : 4'($urandom_range(1, 2));
    emph = 2'($urandom_range(0, 3));
    if (emph == EMPH_BAD) emph = 2'b11;
    bits = $urandom;
    return {SYNC1_CODE, SYNC2_CODE, ver, lay, bits[0], bri, 2'($urandom_range(0, 2)),
            bits[1], bits[2], bits[8:3], emph};
  endfunction

  function automatic string show(input report_t r);
    return $sformatf("status=%0d word=%h kbps=%0d hz=%0d len=%0d ms=%0d skipped=%0d",
                     r.status, r.word, r.kbps, r.hz, r.len, r.ms, r.skipped);
  endfunction

  // Offers one byte, waits for the request to be taken, and records the
  // result it should cause. A typed result replaces the predicted one.
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input bit typed, input report_t typed_rep);
    report_t r;
    bit      got;
    if (!steady() && $urandom_range(0, 99) < 9) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_byte(b, last, got, r);
    if (typed) begin
      got = 1'b1;
      r = typed_rep;
    end
    if (got) begin
      expected_reports.push_back(r);
      reports_due++;
    end
    items_sent++;
  endtask

  // Drops valid, waits for every owed result, then lets a header in flight
  // finish so that the block is idle.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_MATCH_MASK) begin
      cfg_mask = value;
    end else begin
      locked_sig = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One setting of the registers, then a stream built mostly from frames that
  // agree with the base header on the masked bits, with foreign headers, noise,
  // frames that run short or long, and stray buffer ends mixed in.
  task automatic run_phase(input logic [31:0] mask, input logic [31:0] sig,
                           input logic [31:0] base, input int quota);
    int          start;
    int          roll;
    int          extra;
    int          n;
    logic [31:0] hdr;
    report_t     info;
    settle();
    cfg_write(CFG_MATCH_MASK, mask);
    cfg_write(CFG_START_SIG, sig);
    start = items_sent;
    // A buffer end first, so that the stream starts in hunt mode.
    push_byte(8'($urandom), 1'b1, 1'b0, '0);
    while (items_sent - start < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom), buffer_end(), 1'b0, '0);
      end else begin
        hdr = random_header($urandom_range(0, 29) == 0);
        if (roll >= 15 || items_sent - start == 1) hdr = (base & mask) | (hdr & ~mask);
        for (n = 3; n >= 0; n--) push_byte(hdr[8*n +: 8], buffer_end(), 1'b0, '0);
        info = parse_header(hdr);
        extra = 0;
        if (info.status == STAT_FOUND) extra = int'(info.len) - 4;
        if ($urandom_range(0, 9) == 0) extra = extra + int'($urandom_range(0, 4)) - 2;
        repeat (extra) push_byte(8'($urandom), buffer_end(), 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    int          i;
    int          n;
    report_t     typed_rep;
    logic [31:0] hdr;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 24; i++) begin
      typed_rep = '0;
      typed_rep.status = directed_steps[i].status;
      typed_rep.word = directed_steps[i].word;
      push_byte(directed_steps[i].data, directed_steps[i].last, directed_steps[i].typed,
                typed_rep);
    end

    // Default mask, lock on the first header.
    run_phase(MASK_RESET, 32'h0, random_header(1'b0), 350);
    // Full mask: every later frame must repeat the first header exactly.
    run_phase(32'hFFFF_FFFF, 32'h0, random_header(1'b0), 300);
    // Empty mask: headers lock zero, so any valid header is taken.
    run_phase(32'h0, 32'h0, random_header(1'b0), 350);
    // Longest frame at the top bitrate, cut off by a buffer end.
    push_byte(8'($urandom), 1'b1, 1'b0, '0);
    hdr = 32'hFFFB_EA00;
    for (n = 3; n >= 0; n--) push_byte(hdr[8*n +: 8], 1'b0, 1'b0, '0);
    push_byte(8'($urandom), 1'b0, 1'b0, '0);
    push_byte(8'($urandom), 1'b1, 1'b0, '0);
    // Seek an all-ones signature: only unsupported all-ones words can match.
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
    // Seek a given signature from the start.
    hdr = random_header(1'b0);
    run_phase(MASK_RESET, hdr & MASK_RESET, hdr, 350);
    while (reports_due < 60) run_phase(32'h0, 32'h0, 32'h0, 100);

    settle();
    if (failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off once results flow, and
  // the steady window with no gaps.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!stall_done && reports_seen >= 12) begin
      stall_done = 1'b1;
      stall_left = 399;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady() || ($urandom_range(0, 99) >= 9);
    end
  end

  // Each result request taken is checked against the oldest owed result.
  always @(posedge clk) begin : result_check
    report_t seen;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status = out_tuser;
      seen.word = out_tdata[31:0];
      seen.kbps = out_tdata[40:32];
      seen.hz = out_tdata[56:41];
      seen.len = out_tdata[67:57];
      seen.ms = out_tdata[75:68];
      seen.skipped = out_tdata[91:76];
      reports_seen++;
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("tb: result %0d not owed: %s", reports_seen, show(seen));
      end else begin
        want = expected_reports.pop_front();
        if (seen !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("tb: result %0d mismatch", reports_seen);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(seen));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule

>>> mpeg_audio_frame_sync_scanner.f
rtl/core/mafs_pkg.sv
rtl/core/mafs_hdr_dec.sv
rtl/core/mafs_divider.sv
rtl/core/mpeg_audio_frame_sync_scanner.sv
dv/tb.sv
